[rtl/sorted_expiry_timer_queue_assert.svh]
// assertion macros shared by the timer queue modules
`ifndef SORTED_EXPIRY_TIMER_QUEUE_ASSERT_SVH
`define SORTED_EXPIRY_TIMER_QUEUE_ASSERT_SVH

// property that must hold at every edge outside reset
`define SETQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SETQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/setq_pkg.sv]
`timescale 1ns / 1ps

package setq_pkg;

  // default sizes
  localparam int CAPACITY_DEF  = 16;
  localparam int ID_BITS_DEF   = 8;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int IN_ID_W  = 8;
  localparam int IN_TIME_W = 32;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  // most timers expired by one tick
  localparam int MAX_OUT   = 16;
  localparam int MAX_OUT_W = $clog2(MAX_OUT + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_ADJUST = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE            = 3'd0,
    STATUS_EXPIRED         = 3'd1,
    STATUS_FULL            = 3'd2,
    STATUS_NOT_FOUND       = 3'd3,
    STATUS_DUPLICATE       = 3'd4,
    STATUS_NOTHING_EXPIRED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_APPLY  = 2'd1,
    S_INSERT = 2'd2,
    S_TICK   = 2'd3
  } state_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_MATCH  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  // command from the controller to the chain
  typedef struct packed {
    cell_op_t op;
    logic     pop;
  } chain_cmd_t;

  // per-cell control built by the chain
  typedef struct packed {
    cell_op_t op;
    logic     occ;
    logic     at_end;
    logic     rm;
  } cell_ctl_t;

endpackage

[rtl/sorted_expiry_timer_queue.sv]
`timescale 1ns / 1ps
`include "sorted_expiry_timer_queue_assert.svh"

// Sorted timer list built as a chain of cells, each holding one timer (id and
// expiry) in ascending expiry order; no clearing pass after reset. An item is
// accepted in the idle state, where its id lookup starts, and applied in the
// apply state once the output is free; adjust removes and then reinserts in
// the insert state, and a tick pops one expired timer per result beat (at most
// 16 per tick). Each chain shift moves every entry by one cell. Results sit in
// an output register, so a new item can be taken while the last result waits;
// a stalled output holds each result step until the beat is taken.
module sorted_expiry_timer_queue #(
  parameter int CAPACITY  = setq_pkg::CAPACITY_DEF,
  parameter int ID_BITS   = setq_pkg::ID_BITS_DEF,
  parameter int TIME_BITS = setq_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [setq_pkg::KIND_W-1:0]     kind,
  input  logic [setq_pkg::IN_ID_W-1:0]    timer_id,
  input  logic [setq_pkg::IN_TIME_W-1:0]  time_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [setq_pkg::STATUS_W-1:0]   status,
  output logic [setq_pkg::IN_ID_W-1:0]    result_id,
  output logic                            last,
  output logic [setq_pkg::OCC_W-1:0]      occupancy
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int ID_IN  = (ID_BITS < setq_pkg::IN_ID_W) ? ID_BITS : setq_pkg::IN_ID_W;
  localparam int T_IN   = (TIME_BITS < setq_pkg::IN_TIME_W) ? TIME_BITS
                                                           : setq_pkg::IN_TIME_W;
  localparam int NW     = setq_pkg::MAX_OUT_W;

  setq_pkg::state_t      state, state_next;
  setq_pkg::kind_t       kind_q;
  logic [ID_BITS-1:0]    id_q;
  logic [TIME_BITS-1:0]  tv_q;
  logic [CW-1:0]         count, count_next;
  logic [NW-1:0]         tick_n, tick_n_next;

  logic [ID_BITS-1:0]    in_id_m;
  logic [TIME_BITS-1:0]  in_tv_m;
  logic                  in_take;
  logic                  out_free;

  setq_pkg::chain_cmd_t  cmd;
  logic [ID_BITS-1:0]    cmd_id;
  logic                  found;
  logic [ID_BITS-1:0]    head_id;
  logic [TIME_BITS-1:0]  head_exp;
  logic [TIME_BITS-1:0]  next_exp;
  logic                  due;
  logic                  pop_last;

  logic                    load_out;
  setq_pkg::status_t       res_status;
  logic [ID_BITS-1:0]      res_id;
  logic                    res_last;

  // input fields reduced to the stored widths
  assign in_id_m  = ID_BITS'(timer_id[ID_IN-1:0]);
  assign in_tv_m  = TIME_BITS'(time_value[T_IN-1:0]);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // expiry tests at the head of the list
  assign due      = (count != '0) && (head_exp <= tv_q);
  assign pop_last = !((count > CW'(1)) && (tick_n < NW'(setq_pkg::MAX_OUT - 1))
                      && (next_exp <= tv_q));

  setq_chain #(
    .CAPACITY  (CAPACITY),
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .count    (count),
    .new_id   (cmd_id),
    .new_exp  (tv_q),
    .found    (found),
    .head_id  (head_id),
    .head_exp (head_exp),
    .next_exp (next_exp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      setq_pkg::S_IDLE: begin
        if (in_valid) state_next = setq_pkg::S_APPLY;
      end
      setq_pkg::S_APPLY: begin
        if (out_free) begin
          case (kind_q)
            setq_pkg::KIND_ADJUST: state_next = found ? setq_pkg::S_INSERT
                                                      : setq_pkg::S_IDLE;
            setq_pkg::KIND_TICK:   state_next = setq_pkg::S_TICK;
            default:               state_next = setq_pkg::S_IDLE;
          endcase
        end
      end
      setq_pkg::S_INSERT: begin
        if (out_free) state_next = setq_pkg::S_IDLE;
      end
      setq_pkg::S_TICK: begin
        if (out_free && (!due || pop_last)) state_next = setq_pkg::S_IDLE;
      end
      default: state_next = setq_pkg::S_IDLE;
    endcase
  end

  // chain commands and result beats
  always_comb begin
    in_ready    = 1'b0;
    cmd.op      = setq_pkg::CELL_HOLD;
    cmd.pop     = 1'b0;
    cmd_id      = id_q;
    count_next  = count;
    tick_n_next = tick_n;
    load_out    = 1'b0;
    res_status  = setq_pkg::STATUS_DONE;
    res_id      = id_q;
    res_last    = 1'b1;
    case (state)
      setq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd_id      = in_id_m;
        tick_n_next = '0;
        if (in_valid) cmd.op = setq_pkg::CELL_MATCH;
      end
      setq_pkg::S_APPLY: begin
        if (out_free) begin
          case (kind_q)
            setq_pkg::KIND_ADD: begin
              load_out = 1'b1;
              if (found) begin
                res_status = setq_pkg::STATUS_DUPLICATE;
              end else if (count == CW'(CAPACITY)) begin
                res_status = setq_pkg::STATUS_FULL;
              end else begin
                cmd.op     = setq_pkg::CELL_INSERT;
                count_next = count + CW'(1);
              end
            end
            setq_pkg::KIND_ADJUST, setq_pkg::KIND_DELETE: begin
              if (!found) begin
                load_out   = 1'b1;
                res_status = setq_pkg::STATUS_NOT_FOUND;
              end else begin
                cmd.op     = setq_pkg::CELL_REMOVE;
                count_next = count - CW'(1);
                load_out   = (kind_q == setq_pkg::KIND_DELETE);
              end
            end
            default: begin
            end
          endcase
        end
      end
      setq_pkg::S_INSERT: begin
        if (out_free) begin
          cmd.op     = setq_pkg::CELL_INSERT;
          count_next = count + CW'(1);
          load_out   = 1'b1;
        end
      end
      setq_pkg::S_TICK: begin
        if (out_free) begin
          load_out = 1'b1;
          if (due) begin
            cmd.op      = setq_pkg::CELL_REMOVE;
            cmd.pop     = 1'b1;
            count_next  = count - CW'(1);
            tick_n_next = tick_n + NW'(1);
            res_status  = setq_pkg::STATUS_EXPIRED;
            res_id      = head_id;
            res_last    = pop_last;
          end else begin
            res_status = setq_pkg::STATUS_NOTHING_EXPIRED;
            res_id     = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= setq_pkg::S_IDLE;
      count     <= '0;
      tick_n    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      tick_n <= tick_n_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // captured item and result register
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_q <= setq_pkg::kind_t'(kind);
      id_q   <= in_id_m;
      tv_q   <= in_tv_m;
    end
    if (load_out) begin
      status    <= res_status;
      result_id <= setq_pkg::IN_ID_W'(res_id);
      last      <= res_last;
      occupancy <= setq_pkg::OCC_W'(count_next);
    end
  end

  // checks
  `SETQ_ASSERT(a_count_range, count <= CW'(CAPACITY), "held count above capacity")
  `SETQ_NEVER(a_insert_full, cmd.op == setq_pkg::CELL_INSERT && count == CW'(CAPACITY),
              "insert into a full list")
  `SETQ_ASSERT(a_insert_after_apply, state == setq_pkg::S_INSERT |->
               ($past(state) == setq_pkg::S_APPLY || $past(state) == setq_pkg::S_INSERT),
               "reinsert state entered without an adjust")
  `SETQ_ASSERT(a_last_ends_item, load_out && res_last |=> state == setq_pkg::S_IDLE,
               "final beat issued but item still in progress")
  `SETQ_ASSERT(a_tick_limit, tick_n <= NW'(setq_pkg::MAX_OUT), "tick expired too many timers")

endmodule

[rtl/setq_cell.sv]
`timescale 1ns / 1ps

module setq_cell #(
  parameter int ID_BITS   = setq_pkg::ID_BITS_DEF,
  parameter int TIME_BITS = setq_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  setq_pkg::cell_ctl_t   ctl,
  input  logic [ID_BITS-1:0]    new_id,
  input  logic [TIME_BITS-1:0]  new_exp,
  input  logic [ID_BITS-1:0]    left_id,
  input  logic [TIME_BITS-1:0]  left_exp,
  input  logic                  left_r,
  input  logic [ID_BITS-1:0]    right_id,
  input  logic [TIME_BITS-1:0]  right_exp,
  output logic [ID_BITS-1:0]    slot_id,
  output logic [TIME_BITS-1:0]  slot_expiry,
  output logic                  r,
  output logic                  match
);

  // this cell sits at or behind the insert point
  always_comb begin
    r = (ctl.occ && (slot_expiry > new_exp)) || ctl.at_end;
  end

  // id compare, kept until the next lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.op == setq_pkg::CELL_MATCH) begin
      match <= ctl.occ && (slot_id == new_id);
    end
  end

  // entry moves: shift right on insert, shift left on remove
  always_ff @(posedge clk) begin
    case (ctl.op)
      setq_pkg::CELL_INSERT: begin
        if (r && left_r) begin
          slot_id     <= left_id;
          slot_expiry <= left_exp;
        end else if (r) begin
          slot_id     <= new_id;
          slot_expiry <= new_exp;
        end
      end
      setq_pkg::CELL_REMOVE: begin
        if (ctl.rm) begin
          slot_id     <= right_id;
          slot_expiry <= right_exp;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/setq_chain.sv]
`timescale 1ns / 1ps
`include "sorted_expiry_timer_queue_assert.svh"

module setq_chain #(
  parameter int CAPACITY  = setq_pkg::CAPACITY_DEF,
  parameter int ID_BITS   = setq_pkg::ID_BITS_DEF,
  parameter int TIME_BITS = setq_pkg::TIME_BITS_DEF,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  setq_pkg::chain_cmd_t  cmd,
  input  logic [CW-1:0]         count,
  input  logic [ID_BITS-1:0]    new_id,
  input  logic [TIME_BITS-1:0]  new_exp,
  output logic                  found,
  output logic [ID_BITS-1:0]    head_id,
  output logic [TIME_BITS-1:0]  head_exp,
  output logic [TIME_BITS-1:0]  next_exp
);

  logic [ID_BITS-1:0]   id_a  [CAPACITY];
  logic [TIME_BITS-1:0] exp_a [CAPACITY];
  logic [CAPACITY-1:0]  r_a;
  logic [CAPACITY-1:0]  match_a;
  logic [CAPACITY-1:0]  occ_a;
  logic [CAPACITY-1:0]  rm_mask;

  // ids are unique, so the match is one-hot: mark it and every cell behind it, or every cell on a pop
  always_comb begin
    found = |match_a;
    if (cmd.pop) begin
      rm_mask = '1;
    end else begin
      rm_mask = ~(match_a - CAPACITY'(1));
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    setq_pkg::cell_ctl_t  ctl;
    logic [ID_BITS-1:0]   l_id;
    logic [TIME_BITS-1:0] l_exp;
    logic                 l_r;
    logic [ID_BITS-1:0]   rt_id;
    logic [TIME_BITS-1:0] rt_exp;

    // local control for this cell
    assign ctl.op     = cmd.op;
    assign ctl.occ    = count > CW'(i);
    assign ctl.at_end = count == CW'(i);
    assign ctl.rm     = rm_mask[i];
    assign occ_a[i]   = ctl.occ;

    // neighbor links, open at both ends
    if (i == 0) begin : g_first
      assign l_id  = '0;
      assign l_exp = '0;
      assign l_r   = 1'b0;
    end else begin : g_left
      assign l_id  = id_a[i-1];
      assign l_exp = exp_a[i-1];
      assign l_r   = r_a[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rt_id  = '0;
      assign rt_exp = '0;
    end else begin : g_right
      assign rt_id  = id_a[i+1];
      assign rt_exp = exp_a[i+1];
    end

    setq_cell #(
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_id      (new_id),
      .new_exp     (new_exp),
      .left_id     (l_id),
      .left_exp    (l_exp),
      .left_r      (l_r),
      .right_id    (rt_id),
      .right_exp   (rt_exp),
      .slot_id     (id_a[i]),
      .slot_expiry (exp_a[i]),
      .r           (r_a[i]),
      .match       (match_a[i])
    );
  end

  // head of the sorted list
  assign head_id  = id_a[0];
  assign head_exp = exp_a[0];
  assign next_exp = exp_a[1];

  // checks
  `SETQ_ASSERT(a_match_onehot, $onehot0(match_a), "more than one cell matched an id")
  `SETQ_ASSERT(a_match_held, (cmd.op == setq_pkg::CELL_REMOVE && !cmd.pop) |->
               (found && ((match_a & ~occ_a) == '0)), "match flag out of place")
  `SETQ_NEVER(a_pop_empty, cmd.pop && cmd.op == setq_pkg::CELL_REMOVE && count == '0,
              "pop from an empty list")

endmodule

[tb/timer_queue_checker.sv]
`timescale 1ns / 1ps

module timer_queue_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [setq_pkg::KIND_W-1:0]     kind,
  input  logic [setq_pkg::IN_ID_W-1:0]    timer_id,
  input  logic [setq_pkg::IN_TIME_W-1:0]  time_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [setq_pkg::STATUS_W-1:0]   status,
  input  logic [setq_pkg::IN_ID_W-1:0]    result_id,
  input  logic                            last,
  input  logic [setq_pkg::OCC_W-1:0]      occupancy,
  output int                              errors,
  output int                              pending
);
  import setq_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;

  typedef struct packed {
    status_t            st;
    logic [IN_ID_W-1:0] id;
    logic               fin;
    logic [OCC_W-1:0]   occ;
  } timer_result_t;

  // predicted contents of the sorted list
  logic [IN_ID_W-1:0]   held_ids [SLOTS];
  logic [IN_TIME_W-1:0] held_exp [SLOTS];
  int                   held_total;

  timer_result_t        due_results[$];
  int                   mismatch_count;

  function automatic int locate_timer(logic [IN_ID_W-1:0] id);
    for (int i = 0; i < held_total; i++)
      if (held_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_timer(int pos);
    for (int i = pos; i + 1 < held_total; i++) begin
      held_ids[i] = held_ids[i + 1];
      held_exp[i] = held_exp[i + 1];
    end
    if (held_total > 0) held_total--;
  endfunction

  // insert behind every equal expiry
  function automatic void place_timer(logic [IN_ID_W-1:0] id, logic [IN_TIME_W-1:0] exp);
    int pos;
    pos = 0;
    while (pos < held_total && held_exp[pos] <= exp) pos++;
    for (int i = held_total; i > pos; i--) begin
      held_ids[i] = held_ids[i - 1];
      held_exp[i] = held_exp[i - 1];
    end
    held_ids[pos] = id;
    held_exp[pos] = exp;
    held_total++;
  endfunction

  function automatic void queue_result(status_t st, logic [IN_ID_W-1:0] id, logic fin);
    timer_result_t r;
    r.st = st;
    r.id = id;
    r.fin = fin;
    r.occ = held_total[OCC_W-1:0];
    due_results.push_back(r);
  endfunction

  // work out the result beats of one timer operation
  function automatic void apply_timer_op(kind_t k, logic [IN_ID_W-1:0] id,
                                         logic [IN_TIME_W-1:0] tv);
    int pos;
    int n;
    logic [IN_ID_W-1:0] eid;
    logic fin;
    case (k)
      KIND_ADD: begin
        if (locate_timer(id) >= 0) begin
          queue_result(STATUS_DUPLICATE, id, 1'b1);
        end else if (held_total >= SLOTS) begin
          queue_result(STATUS_FULL, id, 1'b1);
        end else begin
          place_timer(id, tv);
          queue_result(STATUS_DONE, id, 1'b1);
        end
      end
      KIND_ADJUST, KIND_DELETE: begin
        pos = locate_timer(id);
        if (pos < 0) begin
          queue_result(STATUS_NOT_FOUND, id, 1'b1);
        end else begin
          drop_timer(pos);
          if (k == KIND_ADJUST) place_timer(id, tv);
          queue_result(STATUS_DONE, id, 1'b1);
        end
      end
      default: begin
        // pop due timers from the head, bounded per tick
        n = 0;
        while (held_total > 0 && n < MAX_OUT && held_exp[0] <= tv) begin
          eid = held_ids[0];
          drop_timer(0);
          fin = !(held_total > 0 && n + 1 < MAX_OUT && held_exp[0] <= tv);
          queue_result(STATUS_EXPIRED, eid, fin);
          n++;
        end
        if (n == 0) queue_result(STATUS_NOTHING_EXPIRED, '0, 1'b1);
      end
    endcase
  endfunction

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      held_total = 0;
      due_results.delete();
    end else begin
      if (in_valid && in_ready)
        apply_timer_op(kind_t'(kind), timer_id, time_value);
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result beat with none expected: status %0d id %0d", status, result_id);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            mismatch_count++;
          end
          if (result_id !== want.id) begin
            $error("result_id: expected %0d, got %0d", want.id, result_id);
            mismatch_count++;
          end
          if (last !== want.fin) begin
            $error("last: expected %0d, got %0d", want.fin, last);
            mismatch_count++;
          end
          if (occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
            mismatch_count++;
          end
        end
      end
    end
    pending <= due_results.size();
    errors <= mismatch_count;
  end

endmodule

[tb/sorted_expiry_timer_queue_tb.sv]
`timescale 1ns / 1ps

module sorted_expiry_timer_queue_tb;
  import setq_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_OPS  = 300;
  localparam int SETTLE      = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    kind = '0;
  logic [IN_ID_W-1:0]   timer_id = '0;
  logic [IN_TIME_W-1:0] time_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [IN_ID_W-1:0]   result_id;
  logic                 last;
  logic [OCC_W-1:0]     occupancy;

  int                   errors;
  int                   pending;
  int                   quiet_cycles = 0;
  logic                 calm = 1'b0;
  logic [IN_TIME_W-1:0] now_time;

  always #10 clk = ~clk;

  sorted_expiry_timer_queue dut (
    .clk, .rst, .in_valid, .in_ready, .kind, .timer_id, .time_value,
    .out_valid, .out_ready, .status, .result_id, .last, .occupancy
  );

  timer_queue_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .kind, .timer_id, .time_value,
    .out_valid, .out_ready, .status, .result_id, .last, .occupancy,
    .errors, .pending
  );

  // receiver stalls at random except in the calm stretch
  always @(posedge clk)
    out_ready <= calm || ($urandom_range(0, 99) >= 7);

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one operation and hold it until accepted
  task automatic send_op(kind_t k, logic [IN_ID_W-1:0] id, logic [IN_TIME_W-1:0] tv);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    timer_id <= id;
    time_value <= tv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    kind_t k;
    logic [IN_ID_W-1:0] id;
    logic [IN_TIME_W-1:0] tv;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, unknown ids, extremes, ties, full list, flush
    send_op(KIND_TICK, 8'd0, 32'd0);
    send_op(KIND_DELETE, 8'd5, 32'd0);
    send_op(KIND_ADJUST, 8'd5, 32'd9);
    send_op(KIND_ADD, 8'd0, 32'd0);
    send_op(KIND_ADD, 8'd255, 32'hFFFF_FFFF);
    send_op(KIND_ADD, 8'd0, 32'd7);
    send_op(KIND_ADJUST, 8'd255, 32'h8000_0000);
    for (int i = 1; i <= 14; i++)
      send_op(KIND_ADD, IN_ID_W'(i), IN_TIME_W'((i % 4) * 100));
    send_op(KIND_ADD, 8'd200, 32'd5);
    send_op(KIND_ADD, 8'd7, 32'd5);
    send_op(KIND_DELETE, 8'd3, 32'd0);
    send_op(KIND_TICK, 8'd0, 32'hFFFF_FFFF);

    // random: small id pool and a slowly advancing clock so timers hit and expire
    now_time = 32'd1000;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 100) calm <= 1'b1;
      if (n == 200) calm <= 1'b0;
      if (n == 150) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 40) k = KIND_ADD;
      else if (pick < 55) k = KIND_ADJUST;
      else if (pick < 70) k = KIND_DELETE;
      else k = KIND_TICK;
      if ($urandom_range(0, 99) < 90) id = IN_ID_W'($urandom_range(0, 19));
      else id = IN_ID_W'($urandom());
      pick = $urandom_range(0, 99);
      if (k == KIND_TICK) begin
        if (pick < 85) now_time = now_time + IN_TIME_W'($urandom_range(0, 60));
        tv = (pick >= 95) ? IN_TIME_W'($urandom()) : now_time;
      end else begin
        tv = (pick < 90) ? now_time + IN_TIME_W'($urandom_range(0, 200))
                         : IN_TIME_W'($urandom());
      end
      send_op(k, id, tv);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (pending != 0) $error("results still missing at end: %0d", pending);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
